// ===== design/rgbed_pkg.sv =====
// shared types, constants and tables for the rgb elevation decoder
`timescale 1ns / 1ps
package rgbed_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ENCODING_MODE  = 3'd0;
  localparam logic [2:0] REG_SOURCE_NO_DATA = 3'd1;
  localparam logic [2:0] REG_MIN_VALID      = 3'd2;
  localparam logic [2:0] REG_MAX_VALID      = 3'd3;
  localparam logic [2:0] REG_MARKER_VALUE   = 3'd4;

  // encoding modes
  localparam logic MODE_TERRARIUM = 1'b0;
  localparam logic MODE_MAPBOX    = 1'b1;

  localparam int HEIGHT_W = 30;  // internal height width
  localparam int OUT_W    = 29;  // output height width
  localparam int CFG_W    = 30;  // widest register

  // reset values
  localparam logic signed [HEIGHT_W-1:0] RST_SOURCE_NO_DATA = -30'sd8388352;
  localparam logic signed [HEIGHT_W-1:0] RST_MIN_VALID      = -30'sd8388608;
  localparam logic signed [HEIGHT_W-1:0] RST_MAX_VALID      = 30'sd426936704;
  localparam logic signed [OUT_W-1:0]    RST_MARKER_VALUE   = -29'sd8388608;

  // decoding constants, heights in 1/256 m
  localparam logic signed [HEIGHT_W-1:0] TERRARIUM_OFF = 30'sd8388608;
  localparam logic signed [HEIGHT_W-1:0] MAPBOX_OFF    = 30'sd2560000;
  localparam logic signed [HEIGHT_W-1:0] LOW_LIMIT     = -30'sd2559744;
  localparam logic signed [HEIGHT_W-1:0] HIGH_LIMIT    = 30'sd255999744;

  // ceil(2^26 / 5): exact floor(v / 5) for any 24 bit v
  localparam logic [23:0] RECIP_5  = 24'd13421773;
  localparam int          RECIP_SH = 26;

  typedef struct packed {
    logic [23:0] v;
    logic [47:0] prod;
  } mul_word_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] h;
  } dec_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] height;
    logic                    is_missing;
  } out_word_t;

  // floor(128 * r / 5) for remainder r of v / 5
  function automatic logic [6:0] frac_of_rem(input logic [2:0] r);
    logic [6:0] f;
    case (r)
      3'd1:    f = 7'd25;
      3'd2:    f = 7'd51;
      3'd3:    f = 7'd76;
      3'd4:    f = 7'd102;
      default: f = 7'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== design/rgbed_mul.sv =====
// first stage: registers the pixel value and its product with the reciprocal of five
`timescale 1ns / 1ps
module rgbed_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [23:0]          in_v,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rgbed_pkg::mul_word_t out_data
);

  logic valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.v    <= in_v;
      out_data.prod <= in_v * rgbed_pkg::RECIP_5;
    end
  end

endmodule

// ===== design/rgbed_decode.sv =====
// second stage: turns the pixel value into a height for the selected encoding
`timescale 1ns / 1ps
module rgbed_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rgbed_pkg::mul_word_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rgbed_pkg::dec_word_t out_data
);

  logic                                   valid;
  logic [21:0]                            quot;
  logic [23:0]                            rem_full;
  logic [6:0]                             frac;
  logic signed [rgbed_pkg::HEIGHT_W-1:0]  h_mapbox;
  logic signed [rgbed_pkg::HEIGHT_W-1:0]  h_terrarium;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    quot        = in_data.prod[47:rgbed_pkg::RECIP_SH];
    rem_full    = in_data.v - ({quot, 2'b00} + {2'b00, quot});
    frac        = rgbed_pkg::frac_of_rem(rem_full[2:0]);
    h_mapbox    = signed'({1'b0, quot, 7'b0}) + signed'({23'b0, frac})
                  - rgbed_pkg::MAPBOX_OFF;
    h_terrarium = signed'({6'b0, in_data.v}) - rgbed_pkg::TERRARIUM_OFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.h <= (mode == rgbed_pkg::MODE_MAPBOX) ? h_mapbox : h_terrarium;
    end
  end

endmodule

// ===== design/rgbed_check.sv =====
// third stage: range and no-data checks, marker substitution, output register
`timescale 1ns / 1ps
module rgbed_check (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [rgbed_pkg::HEIGHT_W-1:0] source_no_data,
  input  logic signed [rgbed_pkg::HEIGHT_W-1:0] min_valid,
  input  logic signed [rgbed_pkg::HEIGHT_W-1:0] max_valid,
  input  logic signed [rgbed_pkg::OUT_W-1:0]    marker_value,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rgbed_pkg::dec_word_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rgbed_pkg::out_word_t                  out_data
);

  logic valid;
  logic missing;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    missing = (in_data.h < rgbed_pkg::LOW_LIMIT) || (in_data.h > rgbed_pkg::HIGH_LIMIT) ||
              (in_data.h == source_no_data) || (in_data.h < min_valid) ||
              (in_data.h > max_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.height     <= missing ? marker_value : in_data.h[rgbed_pkg::OUT_W-1:0];
      out_data.is_missing <= missing;
    end
  end

endmodule

// ===== design/rgb_elevation_decoder.sv =====
// top level of the rgb elevation decoder: config registers and three-stage pipeline
`timescale 1ns / 1ps
// rgb elevation decoder
// turns one rgb byte pixel of an elevation tile into a signed height in
// 1/256 m units, terrarium or mapbox terrain-rgb encoding
// input stream s_axis: one pixel per word, red/green/blue in tdata
// output stream m_axis: height in tdata, missing flag in tuser
// config port: cfg_wen/cfg_index/cfg_data, written while the stream is idle;
//   index 0 mode, 1 source no-data, 2 min valid, 3 max valid, 4 marker
// each pixel word passes the mul, decode and check stage registers to the output
// throughput: one pixel per cycle unless stalled; the reciprocal multiply in the
//   first stage and the 30 bit compares in the last stage set the stage depth
// each stage holds its own valid bit and loads when it is empty or the next
//   stage moves, so a stalled receiver fills the pipe and then pushes back
//   on s_axis_tready without losing or repeating a word
// reset clears the valid bits and loads register defaults (mapbox mode)
module rgb_elevation_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [29:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // height [28:0], zero [31:29]
  output logic        m_axis_tuser    // is_missing
);

  // configuration registers
  logic                                  mode;
  logic signed [rgbed_pkg::HEIGHT_W-1:0] source_no_data;
  logic signed [rgbed_pkg::HEIGHT_W-1:0] min_valid;
  logic signed [rgbed_pkg::HEIGHT_W-1:0] max_valid;
  logic signed [rgbed_pkg::OUT_W-1:0]    marker_value;

  // stage links
  logic                 mul_valid, mul_ready;
  logic                 dec_valid, dec_ready;
  rgbed_pkg::mul_word_t mul_data;
  rgbed_pkg::dec_word_t dec_data;
  rgbed_pkg::out_word_t out_data;
  logic [23:0]          pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= rgbed_pkg::MODE_MAPBOX;
      source_no_data <= rgbed_pkg::RST_SOURCE_NO_DATA;
      min_valid      <= rgbed_pkg::RST_MIN_VALID;
      max_valid      <= rgbed_pkg::RST_MAX_VALID;
      marker_value   <= rgbed_pkg::RST_MARKER_VALUE;
    end else if (cfg_wen) begin
      // indexes past the marker register are dropped
      case (cfg_index)
        rgbed_pkg::REG_ENCODING_MODE:  mode           <= cfg_data[0];
        rgbed_pkg::REG_SOURCE_NO_DATA: source_no_data <= signed'(cfg_data);
        rgbed_pkg::REG_MIN_VALID:      min_valid      <= signed'(cfg_data);
        rgbed_pkg::REG_MAX_VALID:      max_valid      <= signed'(cfg_data);
        rgbed_pkg::REG_MARKER_VALUE:   marker_value   <= signed'(cfg_data[28:0]);
        default: ;
      endcase
    end
  end

  // v = red*65536 + green*256 + blue is just the bytes side by side
  assign pixel = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  rgbed_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_v      (pixel),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  rgbed_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  rgbed_check u_check (
    .clk            (clk),
    .rst            (rst),
    .source_no_data (source_no_data),
    .min_valid      (min_valid),
    .max_valid      (max_valid),
    .marker_value   (marker_value),
    .in_valid       (dec_valid),
    .in_ready       (dec_ready),
    .in_data        (dec_data),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_data       (out_data)
  );

  assign m_axis_tdata = {3'b000, out_data.height};
  assign m_axis_tuser = out_data.is_missing;

endmodule

// ===== bench/tb_rgb_elevation_decoder.sv =====
// testbench for the rgb elevation decoder: directed and random pixels against a height predictor
`timescale 1ns / 1ps
module tb_rgb_elevation_decoder;

  // heights in 1/256 m
  localparam longint TERRARIUM_BIAS = 64'sd8388608;
  localparam longint MAPBOX_BIAS    = 64'sd2560000;
  localparam longint LOWEST_H       = -64'sd2559744;   // -9999 m
  localparam longint HIGHEST_H      = 64'sd255999744;  // 999999 m
  localparam longint REG_FLOOR      = -64'sd8388608;
  localparam longint REG_CEIL       = 64'sd426936704;
  localparam longint MARKER_CEIL    = 64'sd255999744;

  localparam int REG_SLOTS        = 8;   // every index the 3 bit port can name
  localparam int PHASES           = 12;
  localparam int PIXELS_PER_PHASE = 71;
  localparam int DRAIN_CYCLES     = 8;   // pipe is 3 deep, keep some margin
  localparam int MAX_REPORTS      = 10;

  typedef struct {
    logic [rgbed_pkg::OUT_W-1:0] height;
    logic                        missing;
  } height_word_t;

  // predicts the height word of each accepted pixel and checks the output stream in order
  class height_checker;
    logic         mode;
    longint       no_data;
    longint       min_h;
    longint       max_h;
    longint       marker;
    height_word_t expected[$];
    int           errors;

    function new();
      mode    = rgbed_pkg::MODE_MAPBOX;
      no_data = rgbed_pkg::RST_SOURCE_NO_DATA;
      min_h   = rgbed_pkg::RST_MIN_VALID;
      max_h   = rgbed_pkg::RST_MAX_VALID;
      marker  = rgbed_pkg::RST_MARKER_VALUE;
      errors  = 0;
    endfunction

    // registers keep only their own width, signed ones as two's complement
    function void set_reg(logic [2:0] idx, logic [rgbed_pkg::CFG_W-1:0] data);
      case (idx)
        rgbed_pkg::REG_ENCODING_MODE:  mode = data[0];
        rgbed_pkg::REG_SOURCE_NO_DATA: no_data = $signed(data);
        rgbed_pkg::REG_MIN_VALID:      min_h = $signed(data);
        rgbed_pkg::REG_MAX_VALID:      max_h = $signed(data);
        rgbed_pkg::REG_MARKER_VALUE:   marker = $signed(data[rgbed_pkg::OUT_W-1:0]);
        default: ;
      endcase
    endfunction

    // code = red*65536 + green*256 + blue
    function longint decode(logic m, logic [23:0] code);
      longint v;
      v = code;
      if (m == rgbed_pkg::MODE_TERRARIUM) return v - TERRARIUM_BIAS;
      // v*128 is never negative, so the division floors
      return (v * 128) / 5 - MAPBOX_BIAS;
    endfunction

    function void note_code(logic [23:0] code);
      longint       h;
      height_word_t w;
      h = decode(mode, code);
      w.missing = (h < LOWEST_H) || (h > HIGHEST_H) || (h == no_data) ||
                  (h < min_h) || (h > max_h);
      if (w.missing) h = marker;
      w.height = h[rgbed_pkg::OUT_W-1:0];
      expected.push_back(w);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_word(logic [31:0] tdata, logic tuser);
      height_word_t want;
      logic [31:0]  want_data;
      if (expected.size() == 0) begin
        report($sformatf("height word %h with no pixel pending", tdata));
        return;
      end
      want = expected.pop_front();
      want_data = {{(32 - rgbed_pkg::OUT_W){1'b0}}, want.height};
      if (tdata !== want_data)
        report($sformatf("height expected %h got %h", want_data, tdata));
      if (tuser !== want.missing)
        report($sformatf("missing flag expected %b got %b", want.missing, tuser));
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wen = 1'b0;
  logic [2:0]                  cfg_index = '0;
  logic [rgbed_pkg::CFG_W-1:0] cfg_data = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [23:0]                 s_axis_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [31:0]                 m_axis_tdata;        // height [28:0], zero [31:29]
  logic                        m_axis_tuser;        // is_missing

  // idle chance per cycle, in percent
  int send_idle = 21;
  int recv_idle = 53;

  // codes whose heights anchor the no-data value and the valid range of a phase
  logic [23:0] probe_code [3];

  height_checker heights = new();

  rgb_elevation_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // all driver tasks start and end just after a falling edge

  // one register write, enable high for one cycle then low again
  task automatic cfg_write(input logic [2:0] idx, input logic [rgbed_pkg::CFG_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    heights.set_reg(idx, data);
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // one pixel word, with random gaps in front of it
  task automatic send_code(input logic [23:0] code);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {code[7:0], code[15:8], code[23:16]};
    do @(posedge clk); while (!s_axis_tready);
    heights.note_code(code);
    @(negedge clk);
  endtask

  // every pixel gives one word, so an empty queue means an empty pipe
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (heights.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly the register's anchor height, sometimes an extreme, sometimes any bit pattern
  function automatic logic [rgbed_pkg::CFG_W-1:0] pick_reg(input longint anchor,
                                                           input longint extreme);
    int roll;
    roll = $urandom_range(7);
    if (roll < 4) return rgbed_pkg::CFG_W'(anchor);
    if (roll < 6) return rgbed_pkg::CFG_W'(extreme);
    return rgbed_pkg::CFG_W'($urandom);
  endfunction

  task automatic random_setup();
    logic        m;
    logic [23:0] swap;
    longint      marker_pick;
    m = 1'($urandom);
    // upper bits of the mode write are junk the block must drop
    cfg_write(rgbed_pkg::REG_ENCODING_MODE, {29'($urandom), m});
    for (int i = 0; i < 3; i++) probe_code[i] = 24'($urandom);
    // keep the anchored range the right way round
    if (probe_code[1] > probe_code[2]) begin
      swap = probe_code[1];
      probe_code[1] = probe_code[2];
      probe_code[2] = swap;
    end
    cfg_write(rgbed_pkg::REG_SOURCE_NO_DATA,
              pick_reg(heights.decode(m, probe_code[0]),
                       $urandom_range(1) ? REG_CEIL : REG_FLOOR));
    cfg_write(rgbed_pkg::REG_MIN_VALID,
              pick_reg(heights.decode(m, probe_code[1]), REG_FLOOR));
    cfg_write(rgbed_pkg::REG_MAX_VALID,
              pick_reg(heights.decode(m, probe_code[2]), REG_CEIL));
    case ($urandom_range(3))
      0:       marker_pick = MARKER_CEIL;
      1:       marker_pick = REG_FLOOR;
      default: marker_pick = longint'($urandom);
    endcase
    cfg_write(rgbed_pkg::REG_MARKER_VALUE, rgbed_pkg::CFG_W'(marker_pick));
  endtask

  // output side: random stalls, checks every word taken
  initial begin
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        heights.check_word(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: mapbox, full valid range
    send_code(24'h000000);        // -10000 m, under -9999 m
    send_code(24'hFFFFFF);        // far above 999999 m
    send_code(24'd9);             // one step under -9999 m
    send_code(24'd10);            // lowest plausible height
    send_code(24'd10099990);      // exactly 999999 m
    send_code(24'd10099991);      // just over it
    drain();

    // terrarium, plausible window edges
    cfg_write(rgbed_pkg::REG_ENCODING_MODE, {29'd0, rgbed_pkg::MODE_TERRARIUM});
    send_code(24'h000000);
    send_code(24'hFFFFFF);        // highest terrarium height
    send_code(24'd5828863);
    send_code(24'd5828864);       // exactly -9999 m
    drain();

    // source no-data hit at height zero
    cfg_write(rgbed_pkg::REG_SOURCE_NO_DATA, '0);
    send_code(24'h800000);
    send_code(24'h800001);
    drain();

    // inverted valid range rejects everything
    cfg_write(rgbed_pkg::REG_MIN_VALID, 30'd100);
    cfg_write(rgbed_pkg::REG_MAX_VALID, 30'd99);
    send_code(24'h800063);
    send_code(24'h800064);
    drain();

    // all-ones writes read as -1, range of a single height
    cfg_write(rgbed_pkg::REG_MIN_VALID, '1);
    cfg_write(rgbed_pkg::REG_MAX_VALID, '1);
    send_code(24'h7FFFFF);
    send_code(24'h800000);
    send_code(24'h7FFFFE);
    drain();

    // marker write wider than the register, then the top marker
    cfg_write(rgbed_pkg::REG_MARKER_VALUE, 30'h3000_0000);
    send_code(24'h000000);
    drain();
    cfg_write(rgbed_pkg::REG_MARKER_VALUE, rgbed_pkg::CFG_W'(MARKER_CEIL));
    send_code(24'h000000);
    drain();

    // writes past the last register must change nothing
    for (int i = rgbed_pkg::REG_MARKER_VALUE + 1; i < REG_SLOTS; i++)
      cfg_write(3'(i), rgbed_pkg::CFG_W'($urandom));
    send_code(24'h7FFFFF);
    drain();

    // mapbox with no-data at the top of the plausible window
    cfg_write(rgbed_pkg::REG_ENCODING_MODE, {29'd0, rgbed_pkg::MODE_MAPBOX});
    cfg_write(rgbed_pkg::REG_SOURCE_NO_DATA, rgbed_pkg::CFG_W'(HIGHEST_H));
    cfg_write(rgbed_pkg::REG_MIN_VALID, rgbed_pkg::CFG_W'(REG_FLOOR));
    cfg_write(rgbed_pkg::REG_MAX_VALID, rgbed_pkg::CFG_W'(REG_CEIL));
    send_code(24'd10099990);
    send_code(24'd10099989);
    drain();

    // random phases: sender lighter idle first, then receiver, then full rate
    for (int p = 0; p < PHASES; p++) begin
      case (p / 4)
        0: begin
          send_idle = 21;
          recv_idle = 53;
        end
        1: begin
          send_idle = 53;
          recv_idle = 21;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      random_setup();
      for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
        // about a third lands right around the anchored heights
        if ($urandom_range(9) < 3)
          send_code(probe_code[$urandom_range(2)] + 24'($urandom_range(6)) - 24'd3);
        else
          send_code(24'($urandom));
      end
      drain();
    end

    if (heights.errors == 0 && heights.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
